// File: hw/rtl/lldq_pkg.sv
// ----------------------------------------------------------------------------
// lldq_pkg
// Shared types and constants of the lossy lag delay queue: transfer payloads,
// queue entry layout, result kinds, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lldq_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SLOT_COUNT_DEF  = 16;

  // Most entries that one tick may release
  localparam int MAX_RELEASE     = 16;
  localparam int REL_CNT_W       = $clog2(MAX_RELEASE + 1);

  // Configuration port
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOSS_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LAG        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LAG        = 2'd2;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_RELEASED  = 2'd0,
    KIND_ACCEPTED  = 2'd1,
    KIND_DROP_LOSS = 2'd2,
    KIND_DROP_FULL = 2'd3
  } kind_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  packet_handle;
    logic [3:0]  sender_slot;
    logic [15:0] loss_draw;
    logic [15:0] lag_draw;
    logic [7:0]  elapsed_ms;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_handle;
    logic [3:0]  out_slot;
    logic        last;
  } out_item_t;

  // One queue entry as stored in the RAM
  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  handle;
    logic [3:0]  slot;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAG,
    ST_INSERT,
    ST_RELEASE
  } state_t;

endpackage

// File: hw/rtl/lldq_ram.sv
// ----------------------------------------------------------------------------
// lldq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lldq_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/lossy_lag_delay_queue.sv
// ----------------------------------------------------------------------------
// lossy_lag_delay_queue
// Network impairment delay queue: drops packets by loss draw, delays the rest
// by a drawn lag and releases them in due-time order on clock ticks.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. A tick adds
// elapsed_ms to the millisecond clock and releases every due entry from the
// front of the queue (at most 16 per tick), one result per cycle with last
// set on the final one; a tick with nothing due gives no result. An arrival
// gives exactly one result: dropped by loss, dropped because the queue is
// full, or accepted; an arrival from a slot at or above SLOT_COUNT is
// ignored. Results appear for one cycle on out_strobe and cannot be stalled.
// A dropped or ignored arrival leaves busy low. An accepted arrival first
// multiplies out the lag when it is taken, then scales the lag, then runs
// the sorted insert scan, which reads and rewrites the entry RAM one entry
// per cycle and writes the last occupied slot in its final cycle. A tick
// does one RAM read per released entry. The user must write configuration
// only while busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lossy_lag_delay_queue #(
  parameter int QUEUE_DEPTH = lldq_pkg::QUEUE_DEPTH_DEF,
  parameter int SLOT_COUNT  = lldq_pkg::SLOT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  lldq_pkg::in_item_t               in_item,
  // result channel
  output logic                             out_strobe,
  output lldq_pkg::out_item_t              out_item,
  // configuration
  input  logic                             cfg_we,
  input  logic [lldq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lldq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW:0]   DEPTH_W   = QUEUE_DEPTH[PW:0];
  localparam logic [OW-1:0] OCC_FULL  = QUEUE_DEPTH[OW-1:0];
  localparam logic [8:0]    SLOT_LIMIT = SLOT_COUNT[8:0];
  localparam logic [lldq_pkg::REL_CNT_W-1:0] REL_LIMIT =
    lldq_pkg::MAX_RELEASE[lldq_pkg::REL_CNT_W-1:0];

  // Circular index add
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  // Registers
  lldq_pkg::state_t    state_r, state_nxt;
  logic [16:0]         loss_thr_r;
  logic [15:0]         min_lag_r, max_lag_r;
  logic [31:0]         clock_r, clock_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [PW-1:0]       idx_r, idx_nxt;
  logic                inserting_r, inserting_nxt;
  lldq_pkg::entry_t    carry_r, carry_nxt;
  logic [7:0]          handle_r, handle_nxt;
  logic [3:0]          slot_r, slot_nxt;
  logic [31:0]         prod_r, prod_nxt;
  logic [15:0]         rel_r, rel_nxt;
  logic [lldq_pkg::REL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [7:0]          pend_handle_r, pend_handle_nxt;
  logic [3:0]          pend_slot_r, pend_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  lldq_pkg::out_item_t out_item_r, out_item_nxt;

  // RAM port signals
  logic                ram_we;
  logic [PW-1:0]       ram_wr_addr;
  lldq_pkg::entry_t    ram_wr_data;
  logic [PW-1:0]       ram_rd_addr;
  lldq_pkg::entry_t    ram_rd_data;

  // Decode of an accepted command
  logic        accept;
  logic        slot_bad;
  logic        loss_hit;
  logic        q_full;
  logic        arrive_go;
  logic [15:0] lag_hi;
  logic [15:0] lag_range;

  // Shared compare unit and scan decisions
  logic [31:0] diff;
  logic        due_hit;
  logic        at_end;
  logic        place;
  logic        rel_go;
  logic [32:0] div_sum;
  logic [15:0] lag;

  lldq_ram #(
    .WIDTH ($bits(lldq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Decode the command on the input ports
  assign busy      = (state_r != lldq_pkg::ST_IDLE);
  assign accept    = start & ~busy;
  assign slot_bad  = ({5'd0, in_item.sender_slot} >= SLOT_LIMIT);
  assign loss_hit  = ({1'b0, in_item.loss_draw} < loss_thr_r);
  assign q_full    = (occ_r == OCC_FULL);
  assign arrive_go = accept & (in_item.operation == lldq_pkg::OP_ARRIVE) &
                     ~slot_bad & ~loss_hit & ~q_full;
  assign lag_hi    = (max_lag_r < min_lag_r) ? min_lag_r : max_lag_r;
  assign lag_range = lag_hi - min_lag_r;

  // Scale the product by 1/65535: exact for products below 65535 * 2^16
  assign div_sum   = {1'b0, prod_r} + {17'd0, prod_r[31:16]} + 33'd1;
  assign lag       = min_lag_r + div_sum[31:16];

  // Shared subtractor: entry due time relative to the clock
  assign diff      = ram_rd_data.due - clock_r;
  assign due_hit   = (diff == 32'd0) || (diff[31] && (diff[30:0] != 31'd0));
  assign at_end    = (OW'(idx_r) == occ_r);
  assign place     = inserting_r | at_end | (diff >= {16'd0, rel_r});
  assign rel_go    = (occ_r != '0) && (cnt_r < REL_LIMIT) && due_hit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lldq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.operation == lldq_pkg::OP_TICK) begin
            state_nxt = lldq_pkg::ST_RELEASE;
          end else if (arrive_go) begin
            state_nxt = lldq_pkg::ST_LAG;
          end
        end
      end
      lldq_pkg::ST_LAG: begin
        state_nxt = lldq_pkg::ST_INSERT;
      end
      lldq_pkg::ST_INSERT: begin
        if (at_end) begin
          state_nxt = lldq_pkg::ST_IDLE;
        end
      end
      lldq_pkg::ST_RELEASE: begin
        if (!rel_go) begin
          state_nxt = lldq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lldq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    clock_nxt       = clock_r;
    occ_nxt         = occ_r;
    head_nxt        = head_r;
    idx_nxt         = idx_r;
    inserting_nxt   = inserting_r;
    carry_nxt       = carry_r;
    handle_nxt      = handle_r;
    slot_nxt        = slot_r;
    prod_nxt        = prod_r;
    rel_nxt         = rel_r;
    cnt_nxt         = cnt_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;
    pend_slot_nxt   = pend_slot_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = out_item_r;
    ram_we          = 1'b0;
    ram_wr_addr     = wrap_add(head_r, idx_r);
    ram_wr_data     = carry_r;
    ram_rd_addr     = head_r;

    unique case (state_r)
      lldq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.operation == lldq_pkg::OP_TICK) begin
            // advance the clock and start reading the queue front
            clock_nxt      = clock_r + 32'(in_item.elapsed_ms);
            cnt_nxt        = '0;
            pend_valid_nxt = 1'b0;
          end else if (!slot_bad) begin
            out_item_nxt.out_handle = in_item.packet_handle;
            out_item_nxt.out_slot   = in_item.sender_slot;
            out_item_nxt.last       = 1'b1;
            if (loss_hit) begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.kind = lldq_pkg::KIND_DROP_LOSS;
            end else if (q_full) begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.kind = lldq_pkg::KIND_DROP_FULL;
            end else begin
              // hold the packet and multiply out the lag
              handle_nxt = in_item.packet_handle;
              slot_nxt   = in_item.sender_slot;
              prod_nxt   = 32'(lag_range) * 32'(in_item.lag_draw);
            end
          end
        end
      end

      lldq_pkg::ST_LAG: begin
        // form the new entry and fetch the first queued entry
        rel_nxt       = lag;
        carry_nxt.due = clock_r + 32'(lag);
        carry_nxt.handle = handle_r;
        carry_nxt.slot   = slot_r;
        idx_nxt       = '0;
        inserting_nxt = 1'b0;
        ram_rd_addr   = head_r;
      end

      lldq_pkg::ST_INSERT: begin
        // ripple the new entry in ahead of the first entry not due earlier
        if (place) begin
          ram_we        = 1'b1;
          carry_nxt     = ram_rd_data;
          inserting_nxt = 1'b1;
        end
        idx_nxt     = idx_r + 1'b1;
        ram_rd_addr = wrap_add(head_r, idx_nxt);
        if (at_end) begin
          occ_nxt                 = occ_r + 1'b1;
          out_valid_nxt           = 1'b1;
          out_item_nxt.kind       = lldq_pkg::KIND_ACCEPTED;
          out_item_nxt.out_handle = handle_r;
          out_item_nxt.out_slot   = slot_r;
          out_item_nxt.last       = 1'b1;
        end
      end

      lldq_pkg::ST_RELEASE: begin
        // emit the held result once the next decision is known
        out_item_nxt.kind       = lldq_pkg::KIND_RELEASED;
        out_item_nxt.out_handle = pend_handle_r;
        out_item_nxt.out_slot   = pend_slot_r;
        out_item_nxt.last       = ~rel_go;
        out_valid_nxt           = pend_valid_r;
        if (rel_go) begin
          // drop the front entry and fetch the next one
          pend_valid_nxt  = 1'b1;
          pend_handle_nxt = ram_rd_data.handle;
          pend_slot_nxt   = ram_rd_data.slot;
          head_nxt        = wrap_add(head_r, PW'(1));
          occ_nxt         = occ_r - 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
          ram_rd_addr     = head_nxt;
        end else begin
          pend_valid_nxt = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lldq_pkg::ST_IDLE;
      loss_thr_r   <= '0;
      min_lag_r    <= '0;
      max_lag_r    <= '0;
      clock_r      <= '0;
      occ_r        <= '0;
      head_r       <= '0;
      idx_r        <= '0;
      inserting_r  <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clock_r      <= clock_nxt;
      occ_r        <= occ_nxt;
      head_r       <= head_nxt;
      idx_r        <= idx_nxt;
      inserting_r  <= inserting_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lldq_pkg::CFG_LOSS_THRESHOLD: loss_thr_r <= cfg_data;
          lldq_pkg::CFG_MIN_LAG:        min_lag_r  <= cfg_data[15:0];
          lldq_pkg::CFG_MAX_LAG:        max_lag_r  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    carry_r       <= carry_nxt;
    handle_r      <= handle_nxt;
    slot_r        <= slot_nxt;
    prod_r        <= prod_nxt;
    rel_r         <= rel_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_slot_r   <= pend_slot_nxt;
    out_item_r    <= out_item_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

endmodule
